@@ sv/sfdw_pkg.sv @@
`timescale 1ns / 1ps
// shared types, codes and sizes of the sample fifo with overwrite and watermarks
package sfdw_pkg;

  localparam int STAMP_W    = 32;
  localparam int ADDR_W     = 16;
  localparam int VALUE_W    = 16;
  localparam int COUNT_W    = 7;
  localparam int LEVEL_W    = 8;
  localparam int CFG_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int ENTRY_W    = STAMP_W + ADDR_W + VALUE_W;

  localparam int DEPTH_DEF   = 128;
  localparam int MAX_RUN_DEF = 64;
  // command queue between front and back, kept a power of two
  localparam int CMDQ_DEPTH  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_MARK      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_MARK     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EVENTS_ENABLE = 2'd3;

  localparam logic [CFG_W-1:0] CAPACITY_RST = 8'd128;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_PEEK  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_SAMPLE   = 2'd0,
    KIND_OVERFLOW = 2'd1,
    KIND_LOW      = 2'd2,
    KIND_HIGH     = 2'd3
  } kind_t;

  typedef struct packed {
    logic [CFG_W-1:0] capacity;
    logic [CFG_W-1:0] low_mark;
    logic [CFG_W-1:0] high_mark;
    logic             events_enable;
  } cfg_t;

  typedef struct packed {
    action_t              action;
    logic [STAMP_W-1:0]   stamp;
    logic [ADDR_W-1:0]    address;
    logic [VALUE_W-1:0]   value;
    logic [COUNT_W-1:0]   count;
  } cmd_t;

  typedef struct packed {
    logic                 valid;
    kind_t                kind;
    logic [LEVEL_W-1:0]   level;
    logic                 last;
    logic [STAMP_W-1:0]   stamp;
    logic [ADDR_W-1:0]    address;
    logic [VALUE_W-1:0]   value;
  } res_t;

endpackage

@@ sv/sfdw_front.sv @@
`timescale 1ns / 1ps
// front end: takes commands, drops empty pop/peek requests, queues the rest
module sfdw_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_action,
  input  logic [sfdw_pkg::STAMP_W-1:0] in_stamp,
  input  logic [sfdw_pkg::ADDR_W-1:0]  in_register_address,
  input  logic [sfdw_pkg::VALUE_W-1:0] in_sample_value,
  input  logic [sfdw_pkg::COUNT_W-1:0] in_count,
  output logic                         cmd_valid,
  input  logic                         cmd_take,
  output sfdw_pkg::cmd_t               cmd
);

  localparam int QD = sfdw_pkg::CMDQ_DEPTH;
  localparam int PW = $clog2(QD);

  sfdw_pkg::cmd_t q_r [QD];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]    cnt_r, cnt_nxt;

  sfdw_pkg::cmd_t in_cmd;
  logic           accept;
  logic           keep;
  logic           is_read;

  always_comb begin
    in_cmd.action  = sfdw_pkg::action_t'(in_action);
    in_cmd.stamp   = in_stamp;
    in_cmd.address = in_register_address;
    in_cmd.value   = in_sample_value;
    in_cmd.count   = in_count;
  end

  assign busy      = (cnt_r == (PW+1)'(QD));
  assign accept    = start && !busy;
  assign is_read   = (in_cmd.action == sfdw_pkg::ACT_POP) ||
                     (in_cmd.action == sfdw_pkg::ACT_PEEK);
  // a read of zero words changes nothing and gives nothing
  assign keep      = accept && !(is_read && (in_count == '0));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = keep ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = cmd_take ? rd_ptr_r + PW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + (PW+1)'(keep) - (PW+1)'(cmd_take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (keep) begin
      q_r[wr_ptr_r] <= in_cmd;
    end
  end

endmodule

@@ sv/sfdw_back.sv @@
`timescale 1ns / 1ps
// back end: sample store, head and fill tracking, event and sample word sequencing
module sfdw_back #(
  parameter int DEPTH   = sfdw_pkg::DEPTH_DEF,
  parameter int MAX_RUN = sfdw_pkg::MAX_RUN_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  sfdw_pkg::cfg_t cfg,
  input  logic           cmd_valid,
  input  sfdw_pkg::cmd_t cmd,
  output logic           cmd_take,
  output sfdw_pkg::res_t res
);

  localparam int AW  = $clog2(DEPTH);
  localparam int FW  = $clog2(DEPTH + 1);
  localparam int RW  = $clog2(MAX_RUN + 1);
  localparam int CW  = sfdw_pkg::COUNT_W;
  localparam int LVW = sfdw_pkg::LEVEL_W;
  localparam int LW  = (FW > LVW) ? FW : LVW;
  localparam int NW  = (FW > CW) ? FW : CW;
  localparam int SW  = ((AW > RW) ? AW : RW) + 1;
  localparam int EW  = sfdw_pkg::ENTRY_W;
  localparam int VW  = sfdw_pkg::VALUE_W;
  localparam int DW  = sfdw_pkg::ADDR_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVENT,
    ST_RUN
  } state_t;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                             input logic [SW-1:0] b);
    logic [SW-1:0] s;
    s = SW'(a) + b;
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [LVW-1:0] lvl_field(input logic [FW-1:0] f);
    logic [LW-1:0] t;
    t = LW'(f);
    return t[LVW-1:0];
  endfunction

  state_t              state_r, state_nxt;
  logic [AW-1:0]       head_r, head_nxt;
  logic [FW-1:0]       fill_r, fill_nxt;
  logic [2:0]          pend_r, pend_nxt;
  logic [LVW-1:0]      new_level_r, new_level_nxt;
  logic [AW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [RW-1:0]       remain_r, remain_nxt;
  logic [LVW-1:0]      run_level_r, run_level_nxt;
  logic                out_valid_r, out_valid_nxt;
  sfdw_pkg::kind_t     out_kind_r, out_kind_nxt;
  logic [LVW-1:0]      out_level_r, out_level_nxt;
  logic                out_last_r, out_last_nxt;

  logic [EW-1:0]       entries_r [DEPTH];
  logic [EW-1:0]       rd_data_r;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [AW-1:0]       rd_addr;
  logic [EW-1:0]       wr_data;

  // push path
  logic                ovf;
  logic                drop;
  logic [AW-1:0]       head_drop;
  logic [FW-1:0]       fill_drop;
  logic [FW-1:0]       fill_push;
  logic                low_hit;
  logic                high_hit;
  logic [2:0]          ev_new;

  // read path
  logic [CW-1:0]       cnt_sat;
  logic [NW-1:0]       n_full;
  logic [RW-1:0]       n_run;
  logic [FW-1:0]       fill_after;

  // event pick: bit 0 overflow, bit 1 low, bit 2 high
  logic [2:0]          ev_src;
  logic [2:0]          ev_rest;
  logic [LVW-1:0]      ev_new_level;
  sfdw_pkg::kind_t     ev_kind;
  logic [LVW-1:0]      ev_level;

  always_comb begin
    ovf       = (LW'(fill_r) >= LW'(cfg.capacity)) || (fill_r == FW'(DEPTH));
    drop      = ovf && (fill_r != '0);
    head_drop = drop ? wrap_add(head_r, SW'(1)) : head_r;
    fill_drop = drop ? fill_r - FW'(1) : fill_r;
    wr_addr   = wrap_add(head_drop, SW'(fill_drop));
    fill_push = fill_drop + FW'(1);
    low_hit   = cfg.events_enable && (cfg.low_mark != '0) &&
                (LW'(fill_push) <= LW'(cfg.low_mark));
    high_hit  = cfg.events_enable && (cfg.high_mark != '0) &&
                (LW'(fill_push) >= LW'(cfg.high_mark));
    ev_new    = {high_hit, low_hit, cfg.events_enable && ovf};
    wr_data   = {cmd.stamp, cmd.address, cmd.value};
  end

  always_comb begin
    cnt_sat    = (cmd.count > CW'(MAX_RUN)) ? CW'(MAX_RUN) : cmd.count;
    n_full     = (NW'(fill_r) < NW'(cnt_sat)) ? NW'(fill_r) : NW'(cnt_sat);
    n_run      = n_full[RW-1:0];
    fill_after = (cmd.action == sfdw_pkg::ACT_POP) ? fill_r - FW'(n_run) : fill_r;
  end

  always_comb begin
    ev_src       = (state_r == ST_IDLE) ? ev_new : pend_r;
    ev_rest      = ev_src & (ev_src - 3'd1);
    ev_new_level = (state_r == ST_IDLE) ? lvl_field(fill_push) : new_level_r;
    if (ev_src[0]) begin
      ev_kind  = sfdw_pkg::KIND_OVERFLOW;
      ev_level = lvl_field(fill_r);
    end else if (ev_src[1]) begin
      ev_kind  = sfdw_pkg::KIND_LOW;
      ev_level = ev_new_level;
    end else begin
      ev_kind  = sfdw_pkg::KIND_HIGH;
      ev_level = ev_new_level;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    fill_nxt      = fill_r;
    pend_nxt      = pend_r;
    new_level_nxt = new_level_r;
    rd_ptr_nxt    = rd_ptr_r;
    remain_nxt    = remain_r;
    run_level_nxt = run_level_r;
    out_valid_nxt = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_level_nxt = out_level_r;
    out_last_nxt  = 1'b0;
    wr_en         = 1'b0;
    rd_addr       = head_r;
    cmd_take      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_take = 1'b1;
          case (cmd.action)
            sfdw_pkg::ACT_PUSH: begin
              wr_en         = 1'b1;
              head_nxt      = head_drop;
              fill_nxt      = fill_push;
              new_level_nxt = lvl_field(fill_push);
              if (ev_new != '0) begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = ev_kind;
                out_level_nxt = ev_level;
                out_last_nxt  = (ev_rest == '0);
                pend_nxt      = ev_rest;
                if (ev_rest != '0) begin
                  state_nxt = ST_EVENT;
                end
              end
            end
            sfdw_pkg::ACT_POP, sfdw_pkg::ACT_PEEK: begin
              if (n_run != '0) begin
                // first word is read from the head in this cycle
                out_valid_nxt = 1'b1;
                out_kind_nxt  = sfdw_pkg::KIND_SAMPLE;
                out_level_nxt = lvl_field(fill_after);
                out_last_nxt  = (n_run == RW'(1));
                run_level_nxt = lvl_field(fill_after);
                rd_ptr_nxt    = wrap_add(head_r, SW'(1));
                remain_nxt    = n_run - RW'(1);
                if (n_run != RW'(1)) begin
                  state_nxt = ST_RUN;
                end
                if (cmd.action == sfdw_pkg::ACT_POP) begin
                  head_nxt = wrap_add(head_r, SW'(n_run));
                  fill_nxt = fill_after;
                end
              end
            end
            sfdw_pkg::ACT_CLEAR: begin
              head_nxt = '0;
              fill_nxt = '0;
            end
            default: begin
              head_nxt = head_r;
            end
          endcase
        end
      end
      ST_EVENT: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = ev_kind;
        out_level_nxt = ev_level;
        out_last_nxt  = (ev_rest == '0);
        pend_nxt      = ev_rest;
        if (ev_rest == '0) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RUN: begin
        rd_addr       = rd_ptr_r;
        out_valid_nxt = 1'b1;
        out_kind_nxt  = sfdw_pkg::KIND_SAMPLE;
        out_level_nxt = run_level_r;
        out_last_nxt  = (remain_r == RW'(1));
        rd_ptr_nxt    = wrap_add(rd_ptr_r, SW'(1));
        remain_nxt    = remain_r - RW'(1);
        if (remain_r == RW'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      fill_r      <= '0;
      pend_r      <= '0;
      remain_r    <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      pend_r      <= pend_nxt;
      remain_r    <= remain_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
    new_level_r <= new_level_nxt;
    rd_ptr_r    <= rd_ptr_nxt;
    run_level_r <= run_level_nxt;
    out_kind_r  <= out_kind_nxt;
    out_level_r <= out_level_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries_r[wr_addr] <= wr_data;
    end
    rd_data_r <= entries_r[rd_addr];
  end

  // read data lines up with the registered result word
  always_comb begin
    res.valid   = out_valid_r;
    res.kind    = out_kind_r;
    res.level   = out_level_r;
    res.last    = out_last_r;
    if (out_kind_r == sfdw_pkg::KIND_SAMPLE) begin
      res.stamp   = rd_data_r[EW-1:VW+DW];
      res.address = rd_data_r[VW+DW-1:VW];
      res.value   = rd_data_r[VW-1:0];
    end else begin
      res.stamp   = '0;
      res.address = '0;
      res.value   = '0;
    end
  end

endmodule

@@ sv/sample_fifo_drop_oldest_watermarks_core.sv @@
`timescale 1ns / 1ps
// top level: configuration registers, command front end and fifo back end
//
// Commands (push, pop, peek, clear) enter a two-deep command queue; busy is high
// while that queue is full. The back end takes one queued command when it has no
// word left to send; a command is first registered in the queue, then taken by
// the back end, which registers its first result word. A push reports events
// (overflow, low, high, up to three) as event words, if any. Pop and peek send one
// sample word per cycle, paced by the single read port of the sample store; pop or
// peek with count zero is dropped at the front. Result words of one command come
// on back-to-back cycles with out_valid high, out_last on the final one, and must
// be taken as they come. Configuration is written through cfg_we, cfg_index and
// cfg_wdata, and only while idle: a rule on the user that the block leaves unchecked.
module sample_fifo_drop_oldest_watermarks_core #(
  parameter int DEPTH   = sfdw_pkg::DEPTH_DEF,
  parameter int MAX_RUN = sfdw_pkg::MAX_RUN_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_action,
  input  logic [sfdw_pkg::STAMP_W-1:0]   in_stamp,
  input  logic [sfdw_pkg::ADDR_W-1:0]    in_register_address,
  input  logic [sfdw_pkg::VALUE_W-1:0]   in_sample_value,
  input  logic [sfdw_pkg::COUNT_W-1:0]   in_count,
  input  logic                           cfg_we,
  input  logic [sfdw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sfdw_pkg::CFG_W-1:0]     cfg_wdata,
  output logic                           out_valid,
  output logic [1:0]                     out_kind,
  output logic [sfdw_pkg::LEVEL_W-1:0]   out_level,
  output logic [sfdw_pkg::STAMP_W-1:0]   out_stamp,
  output logic [sfdw_pkg::ADDR_W-1:0]    out_address,
  output logic [sfdw_pkg::VALUE_W-1:0]   out_value,
  output logic                           out_last
);

  sfdw_pkg::cfg_t cfg_r, cfg_nxt;
  sfdw_pkg::cmd_t cmd;
  sfdw_pkg::res_t res;
  logic           cmd_valid;
  logic           cmd_take;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        sfdw_pkg::REG_CAPACITY:      cfg_nxt.capacity      = cfg_wdata;
        sfdw_pkg::REG_LOW_MARK:      cfg_nxt.low_mark      = cfg_wdata;
        sfdw_pkg::REG_HIGH_MARK:     cfg_nxt.high_mark     = cfg_wdata;
        sfdw_pkg::REG_EVENTS_ENABLE: cfg_nxt.events_enable = cfg_wdata[0];
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.capacity      <= sfdw_pkg::CAPACITY_RST;
      cfg_r.low_mark      <= '0;
      cfg_r.high_mark     <= '0;
      cfg_r.events_enable <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sfdw_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_action           (in_action),
    .in_stamp            (in_stamp),
    .in_register_address (in_register_address),
    .in_sample_value     (in_sample_value),
    .in_count            (in_count),
    .cmd_valid           (cmd_valid),
    .cmd_take            (cmd_take),
    .cmd                 (cmd)
  );

  sfdw_back #(
    .DEPTH   (DEPTH),
    .MAX_RUN (MAX_RUN)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .res       (res)
  );

  assign out_valid   = res.valid;
  assign out_kind    = res.kind;
  assign out_level   = res.level;
  assign out_stamp   = res.stamp;
  assign out_address = res.address;
  assign out_value   = res.value;
  assign out_last    = res.last;

`ifndef SYNTHESIS
  a_burst_unbroken: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("result burst broke before its last word");

  a_run_level_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last && out_kind == sfdw_pkg::KIND_SAMPLE |=>
      out_kind == sfdw_pkg::KIND_SAMPLE && out_level == $past(out_level))
    else $error("sample run changed kind or level mid-burst");

  a_take_between_bursts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_take |-> !(out_valid && !out_last))
    else $error("back end took a command inside a result burst");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word right after reset");
`endif

endmodule

@@ tb/sample_fifo_drop_oldest_watermarks_core_tb.sv @@
`timescale 1ns / 1ps
// testbench: drives push, pop, peek and clear commands and checks every result word
module sample_fifo_drop_oldest_watermarks_core_tb;

  localparam int DEPTH   = sfdw_pkg::DEPTH_DEF;
  localparam int MAX_RUN = sfdw_pkg::MAX_RUN_DEF;

  typedef struct {
    sfdw_pkg::kind_t              kind;
    logic [sfdw_pkg::LEVEL_W-1:0] level;
    logic [sfdw_pkg::STAMP_W-1:0] stamp;
    logic [sfdw_pkg::ADDR_W-1:0]  address;
    logic [sfdw_pkg::VALUE_W-1:0] value;
    logic                         last;
  } result_word_t;

  // shadow copy of the sample queue; predicts the words each command causes
  class sample_fifo_tracker;
    logic [sfdw_pkg::ENTRY_W-1:0] store [DEPTH];
    int unsigned                  head;
    int unsigned                  fill;
    logic [sfdw_pkg::CFG_W-1:0]   capacity;
    logic [sfdw_pkg::CFG_W-1:0]   low_mark;
    logic [sfdw_pkg::CFG_W-1:0]   high_mark;
    logic                         events_on;
    result_word_t                 expected_words[$];
    result_word_t                 staged[$];
    int                           errors;
    int                           checked;
    int                           commands;

    function new();
      head      = 0;
      fill      = 0;
      capacity  = sfdw_pkg::CAPACITY_RST;
      low_mark  = '0;
      high_mark = '0;
      events_on = 1'b0;
      errors    = 0;
      checked   = 0;
      commands  = 0;
    endfunction

    function void write_reg(logic [sfdw_pkg::CFG_IDX_W-1:0] idx,
                            logic [sfdw_pkg::CFG_W-1:0] data);
      case (idx)
        sfdw_pkg::REG_CAPACITY:      capacity  = data;
        sfdw_pkg::REG_LOW_MARK:      low_mark  = data;
        sfdw_pkg::REG_HIGH_MARK:     high_mark = data;
        sfdw_pkg::REG_EVENTS_ENABLE: events_on = data[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void stage(sfdw_pkg::kind_t k, int unsigned lvl,
                        logic [sfdw_pkg::ENTRY_W-1:0] sample);
      result_word_t w;
      w.kind    = k;
      w.level   = sfdw_pkg::LEVEL_W'(lvl);
      w.stamp   = sample[sfdw_pkg::ENTRY_W-1 -: sfdw_pkg::STAMP_W];
      w.address = sample[sfdw_pkg::VALUE_W +: sfdw_pkg::ADDR_W];
      w.value   = sample[sfdw_pkg::VALUE_W-1:0];
      w.last    = 1'b0;
      staged = {staged, w};
    endfunction

    function void note_command(sfdw_pkg::action_t act, logic [sfdw_pkg::STAMP_W-1:0] stamp,
                               logic [sfdw_pkg::ADDR_W-1:0] addr,
                               logic [sfdw_pkg::VALUE_W-1:0] value,
                               logic [sfdw_pkg::COUNT_W-1:0] count);
      int unsigned n;
      int unsigned after;
      int unsigned i;
      staged.delete();
      commands++;
      case (act)
        sfdw_pkg::ACT_PUSH: begin
          if (fill >= capacity || fill >= DEPTH) begin
            if (events_on) stage(sfdw_pkg::KIND_OVERFLOW, fill, '0);
            // only one sample goes, even when capacity sits far below the fill
            if (fill > 0) begin
              head = (head + 1) % DEPTH;
              fill--;
            end
          end
          store[(head + fill) % DEPTH] = {stamp, addr, value};
          fill++;
          if (events_on && low_mark != 0 && fill <= low_mark)
            stage(sfdw_pkg::KIND_LOW, fill, '0);
          if (events_on && high_mark != 0 && fill >= high_mark)
            stage(sfdw_pkg::KIND_HIGH, fill, '0);
        end
        sfdw_pkg::ACT_POP, sfdw_pkg::ACT_PEEK: begin
          n = count;
          if (n > MAX_RUN) n = MAX_RUN;
          if (n > fill) n = fill;
          after = (act == sfdw_pkg::ACT_POP) ? fill - n : fill;
          for (i = 0; i < n; i++)
            stage(sfdw_pkg::KIND_SAMPLE, after, store[(head + i) % DEPTH]);
          if (act == sfdw_pkg::ACT_POP) begin
            head = (head + n) % DEPTH;
            fill = after;
          end
        end
        default: begin
          head = 0;
          fill = 0;
        end
      endcase
      if (staged.size() > 0) staged[staged.size() - 1].last = 1'b1;
      foreach (staged[j]) expected_words = {expected_words, staged[j]};
    endfunction

    function void check_word(logic [1:0] kind, logic [sfdw_pkg::LEVEL_W-1:0] level,
                             logic [sfdw_pkg::STAMP_W-1:0] stamp,
                             logic [sfdw_pkg::ADDR_W-1:0] addr,
                             logic [sfdw_pkg::VALUE_W-1:0] value, logic last);
      result_word_t w;
      if (expected_words.size() == 0) begin
        $error("result word with none expected: kind %0d level %0d", kind, level);
        errors++;
        return;
      end
      w = expected_words.pop_front();
      checked++;
      if (kind !== w.kind) begin
        $error("kind: expected %0d, got %0d", w.kind, kind);
        errors++;
      end
      if (level !== w.level) begin
        $error("level: expected %0d, got %0d", w.level, level);
        errors++;
      end
      if (stamp !== w.stamp) begin
        $error("out_stamp: expected %h, got %h", w.stamp, stamp);
        errors++;
      end
      if (addr !== w.address) begin
        $error("out_address: expected %h, got %h", w.address, addr);
        errors++;
      end
      if (value !== w.value) begin
        $error("out_value: expected %h, got %h", w.value, value);
        errors++;
      end
      if (last !== w.last) begin
        $error("last: expected %0d, got %0d", w.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           start;
  logic                           busy;
  logic [1:0]                     in_action;
  logic [sfdw_pkg::STAMP_W-1:0]   in_stamp;
  logic [sfdw_pkg::ADDR_W-1:0]    in_register_address;
  logic [sfdw_pkg::VALUE_W-1:0]   in_sample_value;
  logic [sfdw_pkg::COUNT_W-1:0]   in_count;
  logic                           cfg_we;
  logic [sfdw_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [sfdw_pkg::CFG_W-1:0]     cfg_wdata;
  logic                           out_valid;
  logic [1:0]                     out_kind;
  logic [sfdw_pkg::LEVEL_W-1:0]   out_level;
  logic [sfdw_pkg::STAMP_W-1:0]   out_stamp;
  logic [sfdw_pkg::ADDR_W-1:0]    out_address;
  logic [sfdw_pkg::VALUE_W-1:0]   out_value;
  logic                           out_last;

  sample_fifo_tracker tracker = new();
  bit idle_on = 1'b1;
  int settings_used = 0;

  sample_fifo_drop_oldest_watermarks_core u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_action           (in_action),
    .in_stamp            (in_stamp),
    .in_register_address (in_register_address),
    .in_sample_value     (in_sample_value),
    .in_count            (in_count),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .out_valid           (out_valid),
    .out_kind            (out_kind),
    .out_level           (out_level),
    .out_stamp           (out_stamp),
    .out_address         (out_address),
    .out_value           (out_value),
    .out_last            (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      tracker.check_word(out_kind, out_level, out_stamp, out_address, out_value, out_last);
    end
  end

  // one command word; start stays high afterwards until the next one idles first or settle drops it
  task automatic send_cmd(sfdw_pkg::action_t act, logic [sfdw_pkg::STAMP_W-1:0] stamp,
                          logic [sfdw_pkg::ADDR_W-1:0] addr,
                          logic [sfdw_pkg::VALUE_W-1:0] value,
                          logic [sfdw_pkg::COUNT_W-1:0] count);
    int gap;
    gap = 0;
    while (idle_on && $urandom_range(99) < 36) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start               <= 1'b1;
    in_action           <= act;
    in_stamp            <= stamp;
    in_register_address <= addr;
    in_sample_value     <= value;
    in_count            <= count;
    do @(posedge clk); while (busy);
    tracker.note_command(act, stamp, addr, value, count);
  endtask

  // wait out all expected words, then the tail of commands that cause none
  task automatic settle();
    start <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_config(logic [sfdw_pkg::CFG_W-1:0] cap, logic [sfdw_pkg::CFG_W-1:0] low,
                            logic [sfdw_pkg::CFG_W-1:0] high, logic [sfdw_pkg::CFG_W-1:0] ev);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= sfdw_pkg::REG_CAPACITY;
    cfg_wdata <= cap;
    @(posedge clk);
    tracker.write_reg(sfdw_pkg::REG_CAPACITY, cap);
    cfg_index <= sfdw_pkg::REG_LOW_MARK;
    cfg_wdata <= low;
    @(posedge clk);
    tracker.write_reg(sfdw_pkg::REG_LOW_MARK, low);
    cfg_index <= sfdw_pkg::REG_HIGH_MARK;
    cfg_wdata <= high;
    @(posedge clk);
    tracker.write_reg(sfdw_pkg::REG_HIGH_MARK, high);
    cfg_index <= sfdw_pkg::REG_EVENTS_ENABLE;
    cfg_wdata <= ev;
    @(posedge clk);
    tracker.write_reg(sfdw_pkg::REG_EVENTS_ENABLE, ev);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic run_phase(logic [sfdw_pkg::CFG_W-1:0] cap, logic [sfdw_pkg::CFG_W-1:0] low,
                           logic [sfdw_pkg::CFG_W-1:0] high, logic [sfdw_pkg::CFG_W-1:0] ev,
                           int items, int push_pct, bit idles);
    int r;
    int rc;
    sfdw_pkg::action_t act;
    logic [sfdw_pkg::COUNT_W-1:0] count;
    set_config(cap, low, high, ev);
    idle_on = idles;
    for (int k = 0; k < items; k++) begin
      r = $urandom_range(99);
      if (r < push_pct) act = sfdw_pkg::ACT_PUSH;
      else if (r == 99 && push_pct < 90) act = sfdw_pkg::ACT_CLEAR;
      else if (r % 2 == 0) act = sfdw_pkg::ACT_POP;
      else act = sfdw_pkg::ACT_PEEK;
      // mostly short runs, now and then the full range of the count field
      rc = $urandom_range(99);
      if (rc < 80) count = sfdw_pkg::COUNT_W'($urandom_range(8));
      else if (rc < 95) count = sfdw_pkg::COUNT_W'($urandom_range(64));
      else count = sfdw_pkg::COUNT_W'($urandom_range(127));
      send_cmd(act, $urandom, sfdw_pkg::ADDR_W'($urandom), sfdw_pkg::VALUE_W'($urandom),
               count);
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst_n               = 1'b0;
    start               = 1'b0;
    in_action           = sfdw_pkg::ACT_PUSH;
    in_stamp            = '0;
    in_register_address = '0;
    in_sample_value     = '0;
    in_count            = '0;
    cfg_we              = 1'b0;
    cfg_index           = sfdw_pkg::REG_CAPACITY;
    cfg_wdata           = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: events off, so only pop and peek give words
    send_cmd(sfdw_pkg::ACT_POP, '0, '0, '0, 7'd5);
    send_cmd(sfdw_pkg::ACT_PUSH, 32'h0000_0000, 16'h0000, 16'h0000, 7'd0);
    send_cmd(sfdw_pkg::ACT_PUSH, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 7'd127);
    send_cmd(sfdw_pkg::ACT_PUSH, 32'hA5A5_5A5A, 16'h5A5A, 16'hA5A5, 7'd64);
    send_cmd(sfdw_pkg::ACT_PEEK, '0, '0, '0, 7'd127);
    send_cmd(sfdw_pkg::ACT_PEEK, '0, '0, '0, 7'd0);
    send_cmd(sfdw_pkg::ACT_POP, '0, '0, '0, 7'd1);
    send_cmd(sfdw_pkg::ACT_CLEAR, '1, '1, '1, 7'd127);
    send_cmd(sfdw_pkg::ACT_POP, '0, '0, '0, 7'd3);

    // small capacity: overflow, low and high events, overflow and high in one push
    set_config(8'd3, 8'd2, 8'd3, 8'd1);
    for (int k = 0; k < 5; k++) send_cmd(sfdw_pkg::ACT_PUSH, $urandom, 16'(k), 16'(~k), 7'd0);
    send_cmd(sfdw_pkg::ACT_POP, '0, '0, '0, 7'd127);
    send_cmd(sfdw_pkg::ACT_PEEK, '0, '0, '0, 7'd2);

    // capacity zero: every push overflows and one sample stays
    set_config(8'd0, 8'd0, 8'd0, 8'd1);
    for (int k = 0; k < 3; k++)
      send_cmd(sfdw_pkg::ACT_PUSH, $urandom, 16'hF0F0, 16'h0F0F, 7'd1);
    send_cmd(sfdw_pkg::ACT_POP, '0, '0, '0, 7'd64);

    // capacity past the depth, filled to the top
    run_phase(8'd255, 8'd0, 8'd128, 8'd1, 170, 97, 1'b1);
    // capacity dropped far below the fill
    run_phase(8'd5, 8'd3, 8'd5, 8'd1, 50, 55, 1'b1);
    run_phase(8'd128, 8'd128, 8'd1, 8'd1, 60, 60, 1'b1);
    // events off with upper data bits set
    run_phase(8'd1, 8'd1, 8'd0, 8'hFE, 40, 50, 1'b1);
    // back-to-back stretch with no idle cycles
    run_phase(8'd64, 8'd10, 8'd50, 8'd1, 50, 65, 1'b0);

    settle();
    $display("covered %0d commands and %0d result words across %0d register settings",
             tracker.commands, tracker.checked, settings_used);
    $display("capacities 0, 1, 3, 5, 64, 128 and 255; events on and off");
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("** sample_fifo_drop_oldest_watermarks_core: PASSED **");
    end else begin
      $display("** sample_fifo_drop_oldest_watermarks_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d result words still outstanding", tracker.pending());
    $display("** sample_fifo_drop_oldest_watermarks_core: FAILED **");
    $finish;
  end

endmodule

@@ sample_fifo_drop_oldest_watermarks_core.f @@
sv/sfdw_pkg.sv
sv/sfdw_front.sv
sv/sfdw_back.sv
sv/sample_fifo_drop_oldest_watermarks_core.sv
tb/sample_fifo_drop_oldest_watermarks_core_tb.sv
